/* design/tsi_pkg.sv */
// Shared types, constants and store sizes of the triangle shading interpolator.
`default_nettype none

package tsi_pkg;

   // store depths
   localparam int VERTEX_DEPTH = 1024;
   localparam int FACE_DEPTH   = 1024;
   localparam int ATTR_DEPTH   = 4096;

   // store address widths
   localparam int VA_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int FA_W = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
   localparam int AA_W = (ATTR_DEPTH > 1) ? $clog2(ATTR_DEPTH) : 1;
   // wide enough for any store address and for face * 3 + corner
   localparam int WIDE_W = 20;

   // field widths
   localparam int VAL_W    = 32;
   localparam int INDEX_W  = 12;
   localparam int CORNER_W = 10;
   localparam int OPCODE_W = 3;
   localparam int FACE_W   = 3 * CORNER_W + 1;

   // port widths
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 160;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;

   // item queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

   // Q16.16 one
   localparam int ONE_Q = 65536;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NORMALS_PER_VERTEX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COORDS_PER_VERTEX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COORDS_PRESENT     = 2'd2;

   // input opcodes
   localparam logic [OPCODE_W-1:0] OP_VERTEX = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_NORMAL = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_COORD  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_FACE   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SHADE  = 3'd4;

   // classified command held in the queue
   typedef enum logic [2:0] {
      CMD_VERTEX,
      CMD_NORMAL,
      CMD_COORD,
      CMD_FACE,
      CMD_SHADE,
      CMD_BLANK
   } cmd_type;

   typedef struct packed {
      cmd_type                    kind;
      logic [INDEX_W-1:0]         index;
      logic signed [VAL_W-1:0]    val_x;
      logic signed [VAL_W-1:0]    val_y;
      logic signed [VAL_W-1:0]    val_z;
      logic [CORNER_W-1:0]        corner_a;
      logic [CORNER_W-1:0]        corner_b;
      logic [CORNER_W-1:0]        corner_c;
      logic                       smooth;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // face store word
   typedef struct packed {
      logic                smooth;
      logic [CORNER_W-1:0] corner_c;
      logic [CORNER_W-1:0] corner_b;
      logic [CORNER_W-1:0] corner_a;
   } face_type;

   // back end sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FACE_RD,
      ST_FACE_WAIT,
      ST_FETCH,
      ST_EDGE,
      ST_ESHIFT,
      ST_MUL,
      ST_ACC,
      ST_NMAG,
      ST_NSHIFT,
      ST_SQRT,
      ST_DIV_LD,
      ST_DIV,
      ST_OUT
   } back_state_type;

   // what the shared multiplier is working on
   typedef enum logic [1:0] {
      MODE_NRM,
      MODE_CROSS,
      MODE_TEX,
      MODE_SQ
   } mac_mode_type;

endpackage

`default_nettype wire

/* design/tsi_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module tsi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/tsi_front.sv */
// Front end: takes input items, classifies them and drops those that do nothing.
`default_nettype none

module tsi_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tsi_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [tsi_pkg::OPCODE_W-1:0]    req_tuser,
   input  tsi_pkg::queue_status_type       qstat,
   output logic                            push,
   output tsi_pkg::queue_entry_type        entry
);

   logic [31:0] idx32;
   logic        keep;

   assign req_tready = !qstat.full;
   assign idx32      = 32'(req_tdata[11:0]);

   // unpack payload
   always_comb begin
      entry.index    = req_tdata[11:0];
      entry.val_x    = req_tdata[43:12];
      entry.val_y    = req_tdata[75:44];
      entry.val_z    = req_tdata[107:76];
      entry.corner_a = req_tdata[117:108];
      entry.corner_b = req_tdata[127:118];
      entry.corner_c = req_tdata[137:128];
      entry.smooth   = req_tdata[138];
      entry.kind     = tsi_pkg::CMD_BLANK;
      keep           = 1'b0;
      // classify; drop writes past a store and unused opcodes
      unique case (req_tuser)
         tsi_pkg::OP_VERTEX: begin
            entry.kind = tsi_pkg::CMD_VERTEX;
            keep       = idx32 < 32'(tsi_pkg::VERTEX_DEPTH);
         end
         tsi_pkg::OP_NORMAL: begin
            entry.kind = tsi_pkg::CMD_NORMAL;
            keep       = idx32 < 32'(tsi_pkg::ATTR_DEPTH);
         end
         tsi_pkg::OP_COORD: begin
            entry.kind = tsi_pkg::CMD_COORD;
            keep       = idx32 < 32'(tsi_pkg::ATTR_DEPTH);
         end
         tsi_pkg::OP_FACE: begin
            entry.kind = tsi_pkg::CMD_FACE;
            keep       = idx32 < 32'(tsi_pkg::FACE_DEPTH);
         end
         tsi_pkg::OP_SHADE: begin
            entry.kind = (idx32 < 32'(tsi_pkg::FACE_DEPTH)) ? tsi_pkg::CMD_SHADE
                                                            : tsi_pkg::CMD_BLANK;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_tvalid && req_tready && keep;

endmodule

`default_nettype wire

/* design/tsi_queue.sv */
// Short item queue between the front end and the back end.
`default_nettype none

module tsi_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tsi_pkg::queue_entry_type    push_entry,
   input  logic                        pop,
   output tsi_pkg::queue_entry_type    head,
   output tsi_pkg::queue_status_type   qstat
);

   tsi_pkg::queue_entry_type    entry_ff [tsi_pkg::QUEUE_DEPTH];
   logic [tsi_pkg::QP_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tsi_pkg::QP_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tsi_pkg::QC_W-1:0]    count_ff, count_in;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head        = entry_ff[rd_ptr_ff];
   assign qstat.full  = count_ff == tsi_pkg::QC_W'(tsi_pkg::QUEUE_DEPTH);
   assign qstat.empty = count_ff == '0;

endmodule

`default_nettype wire

/* design/tsi_back.sv */
// Back end: mesh stores, store writes and the shading sequencer.
`default_nettype none

module tsi_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tsi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsi_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  tsi_pkg::queue_entry_type        head,
   input  tsi_pkg::queue_status_type       qstat,
   output logic                            pop,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [tsi_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int W = tsi_pkg::WIDE_W;

   // round a Q32.32 product to Q16.16 toward zero
   function automatic logic signed [63:0] q16_trunc(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 16;
      if (p[63] && (p[15:0] != 16'd0)) begin
         s = s + 64'sd1;
      end
      return s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // configuration
   logic npv_ff, cpv_ff, cpr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         npv_ff <= 1'b1;
         cpv_ff <= 1'b1;
         cpr_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tsi_pkg::CSR_NORMALS_PER_VERTEX: npv_ff <= csr_wdata[0];
            tsi_pkg::CSR_COORDS_PER_VERTEX:  cpv_ff <= csr_wdata[0];
            tsi_pkg::CSR_COORDS_PRESENT:     cpr_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath registers
   tsi_pkg::back_state_type  state_ff, state_in;
   tsi_pkg::mac_mode_type    mode_ff;
   logic [tsi_pkg::INDEX_W-1:0]  idx_ff;
   logic [tsi_pkg::CORNER_W-1:0] cn_ff [3];
   logic signed [31:0]       wt_ff [3];
   logic signed [31:0]       attr_ff [3][3];
   logic signed [31:0]       crd_ff [3][2];
   logic [32:0]              emag_ff [6];
   logic                     eneg_ff [6];
   logic signed [63:0]       prod_ff;
   logic signed [63:0]       acc_ff [3];
   logic signed [63:0]       tex_ff [2];
   logic [63:0]              nmag_ff [3];
   logic                     nneg_ff [3];
   logic [63:0]              sq_ff, rt_ff, bit_ff;
   logic [47:0]              rem_ff, dv_ff;
   logic [16:0]              quo_ff;
   logic signed [31:0]       nout_ff [3];
   logic [4:0]               cnt_ff;
   logic [1:0]               comp_ff, term_ff;
   logic                     oor_q_ff;
   logic                     rsp_valid_ff;
   logic [tsi_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // store ports
   logic                        vtx_we, nrm_we, crd_we, face_we;
   logic [W-1:0]                head_idx_w;
   logic [tsi_pkg::VA_W-1:0]    vtx_raddr;
   logic [tsi_pkg::AA_W-1:0]    nrm_raddr, crd_raddr;
   logic [tsi_pkg::FA_W-1:0]    face_raddr;
   logic [95:0]                 vtx_rdata, nrm_rdata;
   logic [63:0]                 crd_rdata;
   logic [tsi_pkg::FACE_W-1:0]  face_rdata;
   tsi_pkg::face_type           face_word;
   tsi_pkg::face_type           face_wdata;

   assign head_idx_w = W'(head.index);
   assign vtx_we     = pop && (head.kind == tsi_pkg::CMD_VERTEX);
   assign nrm_we     = pop && (head.kind == tsi_pkg::CMD_NORMAL);
   assign crd_we     = pop && (head.kind == tsi_pkg::CMD_COORD);
   assign face_we    = pop && (head.kind == tsi_pkg::CMD_FACE);
   assign face_wdata = '{smooth: head.smooth, corner_c: head.corner_c,
                         corner_b: head.corner_b, corner_a: head.corner_a};
   assign face_word  = tsi_pkg::face_type'(face_rdata);

   tsi_ram #(.WIDTH(96), .DEPTH(tsi_pkg::VERTEX_DEPTH)) u_vtx_ram (
      .clock   (clock),
      .wr_en   (vtx_we),
      .wr_addr (head_idx_w[tsi_pkg::VA_W-1:0]),
      .wr_data ({head.val_z, head.val_y, head.val_x}),
      .rd_addr (vtx_raddr),
      .rd_data (vtx_rdata)
   );

   tsi_ram #(.WIDTH(96), .DEPTH(tsi_pkg::ATTR_DEPTH)) u_nrm_ram (
      .clock   (clock),
      .wr_en   (nrm_we),
      .wr_addr (head_idx_w[tsi_pkg::AA_W-1:0]),
      .wr_data ({head.val_z, head.val_y, head.val_x}),
      .rd_addr (nrm_raddr),
      .rd_data (nrm_rdata)
   );

   tsi_ram #(.WIDTH(64), .DEPTH(tsi_pkg::ATTR_DEPTH)) u_crd_ram (
      .clock   (clock),
      .wr_en   (crd_we),
      .wr_addr (head_idx_w[tsi_pkg::AA_W-1:0]),
      .wr_data ({head.val_y, head.val_x}),
      .rd_addr (crd_raddr),
      .rd_data (crd_rdata)
   );

   tsi_ram #(.WIDTH(tsi_pkg::FACE_W), .DEPTH(tsi_pkg::FACE_DEPTH)) u_face_ram (
      .clock   (clock),
      .wr_en   (face_we),
      .wr_addr (head_idx_w[tsi_pkg::FA_W-1:0]),
      .wr_data (face_wdata),
      .rd_addr (face_raddr),
      .rd_data (face_rdata)
   );

   // fetch addresses for corner cnt_ff
   logic [1:0]   fk;
   logic [W-1:0] idx_w, corner_w, face3_w, nrm_w, crd_w;
   logic         fetch_oor;

   always_comb begin
      fk       = cnt_ff[1:0];
      idx_w    = W'(idx_ff);
      corner_w = W'(cn_ff[fk]);
      face3_w  = (idx_w << 1) + idx_w + W'(fk);
      nrm_w    = npv_ff ? corner_w : face3_w;
      crd_w    = cpv_ff ? corner_w : face3_w;
      case (mode_ff)
         tsi_pkg::MODE_CROSS: fetch_oor = 32'(corner_w) >= 32'(tsi_pkg::VERTEX_DEPTH);
         tsi_pkg::MODE_TEX:   fetch_oor = 32'(crd_w) >= 32'(tsi_pkg::ATTR_DEPTH);
         default:             fetch_oor = 32'(nrm_w) >= 32'(tsi_pkg::ATTR_DEPTH);
      endcase
   end

   assign vtx_raddr  = corner_w[tsi_pkg::VA_W-1:0];
   assign nrm_raddr  = nrm_w[tsi_pkg::AA_W-1:0];
   assign crd_raddr  = crd_w[tsi_pkg::AA_W-1:0];
   assign face_raddr = idx_w[tsi_pkg::FA_W-1:0];

   // weight w = 1 - u - v, saturated
   logic signed [33:0] wsum;
   logic signed [31:0] w0;

   assign wsum = 34'sd65536 - 34'(head.val_x) - 34'(head.val_y);
   assign w0   = sat32(64'(wsum));

   // edge vectors of a flat face
   logic signed [32:0] edge_val [6];
   logic signed [31:0] esv [6];
   logic               edge_big;

   always_comb begin
      edge_big = 1'b0;
      for (int k = 0; k < 3; k++) begin
         edge_val[k]     = 33'(attr_ff[1][k]) - 33'(attr_ff[0][k]);
         edge_val[k + 3] = 33'(attr_ff[2][k]) - 33'(attr_ff[0][k]);
      end
      for (int i = 0; i < 6; i++) begin
         edge_big = edge_big || (emag_ff[i][32:30] != 3'd0);
         esv[i]   = eneg_ff[i] ? -$signed({1'b0, emag_ff[i][30:0]})
                               : $signed({1'b0, emag_ff[i][30:0]});
      end
   end

   // multiplier operands
   logic signed [31:0] opa, opb;
   logic signed [63:0] prod;
   logic [1:0]         last_term, last_comp;
   logic               mac_last;

   always_comb begin
      opa = '0;
      opb = '0;
      case (mode_ff)
         tsi_pkg::MODE_NRM: begin
            opa = wt_ff[term_ff];
            opb = attr_ff[term_ff][comp_ff];
         end
         tsi_pkg::MODE_TEX: begin
            opa = wt_ff[term_ff];
            opb = crd_ff[term_ff][comp_ff[0]];
         end
         tsi_pkg::MODE_SQ: begin
            opa = $signed(nmag_ff[comp_ff][31:0]);
            opb = $signed(nmag_ff[comp_ff][31:0]);
         end
         default: begin
            // cross product terms, second term of each component subtracted
            case ({comp_ff, term_ff[0]})
               3'b000:  begin opa = esv[1]; opb = esv[5]; end
               3'b001:  begin opa = esv[2]; opb = esv[4]; end
               3'b010:  begin opa = esv[2]; opb = esv[3]; end
               3'b011:  begin opa = esv[0]; opb = esv[5]; end
               3'b100:  begin opa = esv[0]; opb = esv[4]; end
               default: begin opa = esv[1]; opb = esv[3]; end
            endcase
         end
      endcase
      case (mode_ff)
         tsi_pkg::MODE_CROSS: last_term = 2'd1;
         tsi_pkg::MODE_SQ:    last_term = 2'd0;
         default:             last_term = 2'd2;
      endcase
      last_comp = (mode_ff == tsi_pkg::MODE_TEX) ? 2'd1 : 2'd2;
      mac_last  = (term_ff == last_term) && (comp_ff == last_comp);
   end

   assign prod = opa * opb;

   // normalizing shift conditions
   logic nzero, n_big, n_small;

   always_comb begin
      nzero   = 1'b1;
      n_big   = 1'b0;
      n_small = 1'b1;
      for (int k = 0; k < 3; k++) begin
         nzero   = nzero && (acc_ff[k] == 64'sd0);
         n_big   = n_big || (nmag_ff[k][63:30] != '0);
         n_small = n_small && (nmag_ff[k][63:29] == '0);
      end
   end

   // square root and divider steps
   logic [63:0] sq_t;
   logic        sq_ge, div_ge;
   logic [16:0] quo_next;

   assign sq_t     = rt_ff + bit_ff;
   assign sq_ge    = sq_ff >= sq_t;
   assign div_ge   = rem_ff >= dv_ff;
   assign quo_next = {quo_ff[15:0], div_ge};

   logic out_load;

   assign out_load = (state_ff == tsi_pkg::ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      unique case (state_ff)
         tsi_pkg::ST_IDLE: begin
            if (!qstat.empty) begin
               pop = 1'b1;
               case (head.kind)
                  tsi_pkg::CMD_SHADE: state_in = tsi_pkg::ST_FACE_RD;
                  tsi_pkg::CMD_BLANK: state_in = tsi_pkg::ST_OUT;
                  default:            state_in = tsi_pkg::ST_IDLE;
               endcase
            end
         end
         tsi_pkg::ST_FACE_RD:   state_in = tsi_pkg::ST_FACE_WAIT;
         tsi_pkg::ST_FACE_WAIT: state_in = tsi_pkg::ST_FETCH;
         tsi_pkg::ST_FETCH: begin
            if (cnt_ff == 5'd3) begin
               state_in = (mode_ff == tsi_pkg::MODE_CROSS) ? tsi_pkg::ST_EDGE
                                                           : tsi_pkg::ST_MUL;
            end
         end
         tsi_pkg::ST_EDGE: state_in = tsi_pkg::ST_ESHIFT;
         tsi_pkg::ST_ESHIFT: begin
            if (!edge_big) begin
               state_in = tsi_pkg::ST_MUL;
            end
         end
         tsi_pkg::ST_MUL: state_in = tsi_pkg::ST_ACC;
         tsi_pkg::ST_ACC: begin
            if (!mac_last) begin
               state_in = tsi_pkg::ST_MUL;
            end else begin
               case (mode_ff)
                  tsi_pkg::MODE_TEX: state_in = tsi_pkg::ST_NMAG;
                  tsi_pkg::MODE_SQ:  state_in = tsi_pkg::ST_SQRT;
                  default:           state_in = cpr_ff ? tsi_pkg::ST_FETCH
                                                       : tsi_pkg::ST_NMAG;
               endcase
            end
         end
         tsi_pkg::ST_NMAG: state_in = nzero ? tsi_pkg::ST_OUT : tsi_pkg::ST_NSHIFT;
         tsi_pkg::ST_NSHIFT: begin
            if (!n_big && !n_small) begin
               state_in = tsi_pkg::ST_MUL;
            end
         end
         tsi_pkg::ST_SQRT: begin
            if (cnt_ff == 5'd31) begin
               state_in = tsi_pkg::ST_DIV_LD;
            end
         end
         tsi_pkg::ST_DIV_LD: state_in = tsi_pkg::ST_DIV;
         tsi_pkg::ST_DIV: begin
            if (cnt_ff == 5'd16) begin
               state_in = (comp_ff == 2'd2) ? tsi_pkg::ST_OUT : tsi_pkg::ST_DIV_LD;
            end
         end
         tsi_pkg::ST_OUT: begin
            if (out_load) begin
               state_in = tsi_pkg::ST_IDLE;
            end
         end
         default: state_in = tsi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         tsi_pkg::ST_IDLE: begin
            if (pop) begin
               idx_ff   <= head.index;
               wt_ff[0] <= w0;
               wt_ff[1] <= head.val_x;
               wt_ff[2] <= head.val_y;
               for (int k = 0; k < 3; k++) nout_ff[k] <= '0;
               for (int k = 0; k < 2; k++) tex_ff[k] <= '0;
            end
         end
         tsi_pkg::ST_FACE_WAIT: begin
            cn_ff[0] <= face_word.corner_a;
            cn_ff[1] <= face_word.corner_b;
            cn_ff[2] <= face_word.corner_c;
            mode_ff  <= face_word.smooth ? tsi_pkg::MODE_NRM : tsi_pkg::MODE_CROSS;
            for (int k = 0; k < 3; k++) acc_ff[k] <= '0;
            cnt_ff   <= '0;
         end
         tsi_pkg::ST_FETCH: begin
            // issue corner cnt, capture the corner issued in the cycle before
            cnt_ff   <= cnt_ff + 1'b1;
            oor_q_ff <= fetch_oor;
            comp_ff  <= '0;
            term_ff  <= '0;
            if (cnt_ff != 5'd0) begin
               if (mode_ff == tsi_pkg::MODE_TEX) begin
                  crd_ff[fk - 2'd1][0] <= oor_q_ff ? '0 : $signed(crd_rdata[31:0]);
                  crd_ff[fk - 2'd1][1] <= oor_q_ff ? '0 : $signed(crd_rdata[63:32]);
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     attr_ff[fk - 2'd1][k] <= oor_q_ff ? '0 :
                        ((mode_ff == tsi_pkg::MODE_CROSS) ?
                           $signed(vtx_rdata[32*k +: 32]) : $signed(nrm_rdata[32*k +: 32]));
                  end
               end
            end
         end
         tsi_pkg::ST_EDGE: begin
            for (int i = 0; i < 6; i++) begin
               eneg_ff[i] <= edge_val[i][32];
               emag_ff[i] <= edge_val[i][32] ? 33'(-edge_val[i]) : 33'(edge_val[i]);
            end
         end
         tsi_pkg::ST_ESHIFT: begin
            if (edge_big) begin
               for (int i = 0; i < 6; i++) emag_ff[i] <= emag_ff[i] >> 1;
            end
         end
         tsi_pkg::ST_MUL: begin
            prod_ff <= prod;
         end
         tsi_pkg::ST_ACC: begin
            // accumulate one product
            case (mode_ff)
               tsi_pkg::MODE_NRM:
                  acc_ff[comp_ff] <= acc_ff[comp_ff] + q16_trunc(prod_ff);
               tsi_pkg::MODE_CROSS:
                  acc_ff[comp_ff] <= term_ff[0] ? acc_ff[comp_ff] - prod_ff
                                                : acc_ff[comp_ff] + prod_ff;
               tsi_pkg::MODE_TEX:
                  tex_ff[comp_ff[0]] <= tex_ff[comp_ff[0]] + q16_trunc(prod_ff);
               default:
                  sq_ff <= sq_ff + 64'(prod_ff);
            endcase
            // advance term, then component
            if (term_ff == last_term) begin
               term_ff <= '0;
               comp_ff <= comp_ff + 1'b1;
            end else begin
               term_ff <= term_ff + 1'b1;
            end
            if (mac_last) begin
               cnt_ff <= '0;
               rt_ff  <= '0;
               bit_ff <= 64'd1 << 62;
               if (mode_ff == tsi_pkg::MODE_NRM || mode_ff == tsi_pkg::MODE_CROSS) begin
                  mode_ff <= tsi_pkg::MODE_TEX;
               end
            end
         end
         tsi_pkg::ST_NMAG: begin
            for (int k = 0; k < 3; k++) begin
               nneg_ff[k] <= acc_ff[k][63];
               nmag_ff[k] <= acc_ff[k][63] ? 64'(-acc_ff[k]) : 64'(acc_ff[k]);
            end
         end
         tsi_pkg::ST_NSHIFT: begin
            // bring the largest magnitude into [2^29, 2^30)
            if (n_big) begin
               for (int k = 0; k < 3; k++) nmag_ff[k] <= nmag_ff[k] >> 1;
            end else if (n_small) begin
               for (int k = 0; k < 3; k++) nmag_ff[k] <= nmag_ff[k] << 1;
            end else begin
               sq_ff   <= '0;
               mode_ff <= tsi_pkg::MODE_SQ;
               comp_ff <= '0;
               term_ff <= '0;
            end
         end
         tsi_pkg::ST_SQRT: begin
            // one result bit per cycle
            if (sq_ge) begin
               sq_ff <= sq_ff - sq_t;
               rt_ff <= (rt_ff >> 1) + bit_ff;
            end else begin
               rt_ff <= rt_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            cnt_ff  <= cnt_ff + 1'b1;
            comp_ff <= '0;
         end
         tsi_pkg::ST_DIV_LD: begin
            rem_ff <= 48'(nmag_ff[comp_ff]) << 16;
            dv_ff  <= 48'(rt_ff[31:0]) << 16;
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         tsi_pkg::ST_DIV: begin
            // one quotient bit per cycle
            if (div_ge) begin
               rem_ff <= rem_ff - dv_ff;
            end
            dv_ff  <= dv_ff >> 1;
            quo_ff <= quo_next;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'd16) begin
               nout_ff[comp_ff] <= nneg_ff[comp_ff] ? -$signed(32'(quo_next))
                                                    : $signed(32'(quo_next));
               comp_ff <= comp_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {sat32(tex_ff[1]), sat32(tex_ff[0]),
                         nout_ff[2], nout_ff[1], nout_ff[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* design/triangle_shading_interpolator.sv */
// Top level of the triangle shading interpolator.
//
// Holds a triangle mesh (vertices, normals, texture coordinates, faces) and
// shades hit points: a shade item names a face and barycentrics u, v and
// returns the unit shading normal (interpolated for smooth faces, the cross
// product for flat ones) and, when coordinates are present, the interpolated
// texture coordinate, all signed Q16.16. Write items are stored by the back end
// and return nothing. A shade item runs on the one shared 32x32 multiplier, the
// one-bit-per-cycle normalizing shifter, the 32-step square root and three
// 17-step divisions. A four-item queue keeps the input open while the back end
// works and a finished result waits in the output register.
`default_nettype none

module triangle_shading_interpolator (
   input  logic                            clock,
   input  logic                            reset,
   // item in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // index, value_x, value_y, value_z, corner_a, corner_b, corner_c, smooth_face
   input  logic [tsi_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode
   input  logic [tsi_pkg::OPCODE_W-1:0]    req_tuser,
   // result out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // normal_x, normal_y, normal_z, tex_s, tex_t
   output logic [tsi_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration writes
   input  logic                            csr_wr_en,
   input  logic [tsi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsi_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tsi_pkg::queue_entry_type  push_entry;
   tsi_pkg::queue_entry_type  head;
   tsi_pkg::queue_status_type qstat;
   logic                      push;
   logic                      pop;

   tsi_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .entry      (push_entry)
   );

   tsi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   tsi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* design/tsi_checker.sv */
// Port checker for the triangle shading interpolator, bound to the top level.
`default_nettype none

module tsi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tsi_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // hold a stalled result
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result straight out of reset
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result shown right after reset");

   // a unit normal never exceeds one in any component
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[31:0]) <= 32'sd65536 && $signed(rsp_tdata[31:0]) >= -32'sd65536 &&
         $signed(rsp_tdata[63:32]) <= 32'sd65536 && $signed(rsp_tdata[63:32]) >= -32'sd65536 &&
         $signed(rsp_tdata[95:64]) <= 32'sd65536 && $signed(rsp_tdata[95:64]) >= -32'sd65536)
      else $error("normal component out of unit range");

endmodule

bind triangle_shading_interpolator tsi_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
